@@ hdl/tcs_pkg.sv @@
// Package for the tick-driven process scheduler: payload types, register codes,
// controller state enum and the controller-to-datapath command struct. No dependencies.
package tcs_pkg;

    localparam int MaxProcs = 16;
    localparam int IdxW     = 4;
    localparam int TimeW    = 16;
    localparam int CntW     = 16;

    localparam logic [1:0] MODE_FCFS = 2'd0;
    localparam logic [1:0] MODE_RR   = 2'd1;
    localparam logic [1:0] MODE_HRRN = 2'd2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [2:0] ST_NOT_ARRIVED = 3'd0;
    localparam logic [2:0] ST_QUEUED      = 3'd1;
    localparam logic [2:0] ST_RUNNING     = 3'd2;
    localparam logic [2:0] ST_WAITING     = 3'd3;
    localparam logic [2:0] ST_COMPLETE    = 3'd4;

    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_QUANTUM = 2'd1;
    localparam logic [1:0] REG_COUNT   = 2'd2;

    typedef struct packed {
        logic             opcode;
        logic [IdxW-1:0]  proc_index;
        logic [TimeW-1:0] arrival_time;
        logic [CntW-1:0]  burst_length;
    } in_item_t;

    typedef struct packed {
        logic [IdxW-1:0]  out_index;
        logic [2:0]       status_code;
        logic [TimeW-1:0] tick_time;
        logic             last_of_tick;
        logic             all_done;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SORT,
        S_DIV,
        S_CMP,
        S_TAKE,
        S_PREEMPT,
        S_WALK,
        S_EMIT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic tick_start;
        logic sort_init;
        logic div_start;
        logic sort_step;
        logic take_step;
        logic preempt;
        logic walk_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic sort_done;
        logic div_done;
        logic take_done;
        logic need_preempt;
        logic walk_last;
        logic walk_empty;
    } stat_t;

endpackage

@@ hdl/tcs_ctrl.sv @@
// Controller state machine of the scheduler: sequences load, HRRN sort,
// dispatch, walk and result beats. Depends on tcs_pkg.
module tcs_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_op,
    output logic                 in_stall,
    input  logic                 out_stall,
    output logic                 out_valid,
    input  logic [1:0]           mode,
    input  tcs_pkg::stat_t       stat,
    output tcs_pkg::cmd_t        cmd
);

    tcs_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            tcs_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (in_op == tcs_pkg::OP_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else
                    begin
                        cmd.tick_start = 1'b1;
                        if (mode == tcs_pkg::MODE_HRRN)
                        begin
                            cmd.sort_init = 1'b1;
                            state_next    = tcs_pkg::S_SORT;
                        end
                        else
                        begin
                            state_next = tcs_pkg::S_TAKE;
                        end
                    end
                end
            end
            tcs_pkg::S_SORT:
            begin
                if (stat.sort_done)
                begin
                    state_next = tcs_pkg::S_TAKE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = tcs_pkg::S_DIV;
                end
            end
            tcs_pkg::S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = tcs_pkg::S_CMP;
                end
            end
            tcs_pkg::S_CMP:
            begin
                cmd.sort_step = 1'b1;
                state_next    = tcs_pkg::S_SORT;
            end
            tcs_pkg::S_TAKE:
            begin
                if (stat.take_done)
                begin
                    if (stat.need_preempt)
                    begin
                        cmd.preempt = 1'b1;
                        state_next  = tcs_pkg::S_PREEMPT;
                    end
                    else if (stat.walk_empty)
                    begin
                        state_next = tcs_pkg::S_FINISH;
                    end
                    else
                    begin
                        state_next = tcs_pkg::S_WALK;
                    end
                end
                else
                begin
                    cmd.take_step = 1'b1;
                end
            end
            tcs_pkg::S_PREEMPT:
            begin
                if (stat.take_done)
                begin
                    state_next = stat.walk_empty ? tcs_pkg::S_FINISH : tcs_pkg::S_WALK;
                end
                else
                begin
                    cmd.take_step = 1'b1;
                end
            end
            tcs_pkg::S_WALK:
            begin
                cmd.walk_step = 1'b1;
                state_next    = stat.walk_last ? tcs_pkg::S_FINISH : tcs_pkg::S_WALK;
            end
            tcs_pkg::S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = stat.walk_empty ? tcs_pkg::S_IDLE : tcs_pkg::S_EMIT;
            end
            tcs_pkg::S_EMIT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    cmd.walk_step = 1'b1;
                    if (stat.walk_last)
                    begin
                        state_next = tcs_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = tcs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/tcs_datapath.sv @@
// Datapath of the scheduler: process tables, ready queue, serial ratio divider,
// insertion sort, dispatch and walk logic, result buffer. Depends on tcs_pkg.
module tcs_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcs_pkg::in_item_t    in_item,
    input  logic [1:0]           mode,
    input  logic [7:0]           quantum,
    input  logic [4:0]           proc_count,
    input  tcs_pkg::cmd_t        cmd,
    output tcs_pkg::stat_t       stat,
    output tcs_pkg::out_item_t   out_item
);

    localparam int N  = tcs_pkg::MaxProcs;
    localparam int IW = tcs_pkg::IdxW;
    localparam int CW = tcs_pkg::CntW;
    localparam int TW = tcs_pkg::TimeW;
    localparam int DW = CW + 1;

    logic [TW-1:0] arr_reg   [N];
    logic [CW-1:0] burst_reg [N];
    logic [CW-1:0] run_reg   [N];
    logic [CW-1:0] wait_reg  [N];
    logic [N-1:0]  ready_reg;
    logic [N-1:0]  done_reg;
    logic [IW-1:0] q_reg     [N];
    logic [IW:0]   qlen_reg;
    logic          rv_reg;
    logic [IW-1:0] ri_reg;
    logic [7:0]    slice_reg;
    logic [TW-1:0] now_reg;
    logic [TW-1:0] tick_now_reg;
    logic [IW:0]   n_reg;
    logic [IW:0]   walk_reg;
    logic          fin_reg;
    logic [2:0]    res_st_reg [N];
    logic          walk_phase_reg;

    // Insertion sort: i outer, j inner, key ratio held.
    logic [IW:0]   si_reg;
    logic [IW:0]   sj_reg;
    logic          sin_reg;
    logic [IW-1:0] skey_reg;
    logic [DW-1:0] kratio_reg;
    logic          dkey_reg;
    logic [DW-1:0] dq_reg;
    logic [DW-1:0] drem_reg;
    logic [CW-1:0] ddiv_reg;
    logic [4:0]    dcnt_reg;
    logic          dbusy_reg;

    logic [DW-1:0] num;
    logic [CW-1:0] den;
    logic [IW-1:0] dsel;
    logic [DW:0]   trial;
    logic [DW-1:0] rnow;
    logic [IW:0]   n_eff;
    logic [IW-1:0] wi;
    logic          head_ok;

    logic [2:0]    st;
    logic [CW-1:0] run_new;
    logic          rv_new;
    logic          walk_done;
    logic          rv_walk;
    logic [IW-1:0] ri_new;
    logic [7:0]    slice_new;

    function automatic logic all_done_calc();
        logic a;
        a = 1'b1;
        for (int k = 0; k < N; k++)
        begin
            if ((IW+1)'(k) < n_reg && !done_reg[k])
            begin
                a = 1'b0;
            end
        end
        return a;
    endfunction

    assign n_eff = (proc_count > 5'(N)) ? (IW+1)'(N) : proc_count[IW:0];
    assign wi    = walk_reg[IW-1:0];
    assign dsel  = sin_reg ? q_reg[sj_reg[IW-1:0] - 1'b1] : q_reg[si_reg[IW-1:0]];
    assign num   = {1'b0, wait_reg[dsel]} + {1'b0, burst_reg[dsel]};
    assign den   = burst_reg[dsel];
    assign trial = {drem_reg, dq_reg[DW-1]} - {2'b0, ddiv_reg};
    assign rnow  = (ddiv_reg == '0) ? '1 : dq_reg;
    assign head_ok = !done_reg[q_reg[0]];

    assign stat.sort_done    = !sin_reg && (si_reg >= qlen_reg);
    assign stat.div_done     = !dbusy_reg;
    assign stat.take_done    = rv_reg || (qlen_reg == '0);
    assign stat.need_preempt = (mode == tcs_pkg::MODE_RR) && rv_reg && (quantum != '0)
                               && (slice_reg >= quantum);
    assign stat.walk_last    = (walk_reg + 1'b1 == n_reg);
    assign stat.walk_empty   = (n_reg == '0);

    assign out_item.out_index    = wi;
    assign out_item.status_code  = res_st_reg[wi];
    assign out_item.tick_time    = tick_now_reg;
    assign out_item.last_of_tick = stat.walk_last;
    assign out_item.all_done     = fin_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            arr_reg[in_item.proc_index]   <= in_item.arrival_time;
            burst_reg[in_item.proc_index] <= in_item.burst_length;
        end
    end

    // Walk: one entry per cycle in the walk phase (tracked by walk_phase_reg).
    always_comb
    begin
        st        = tcs_pkg::ST_NOT_ARRIVED;
        run_new   = run_reg[wi];
        rv_new    = rv_reg;
        slice_new = slice_reg;
        if (done_reg[wi])
        begin
            st = tcs_pkg::ST_COMPLETE;
        end
        else if (rv_reg && ri_reg == wi)
        begin
            st        = tcs_pkg::ST_RUNNING;
            run_new   = (run_reg[wi] == '1) ? run_reg[wi] : run_reg[wi] + 1'b1;
            slice_new = (slice_reg == '1) ? slice_reg : slice_reg + 1'b1;
        end
        else if (ready_reg[wi])
        begin
            st = tcs_pkg::ST_WAITING;
        end
        else if (arr_reg[wi] == tick_now_reg)
        begin
            if (!rv_reg)
            begin
                st      = tcs_pkg::ST_RUNNING;
                rv_new  = 1'b1;
                run_new = (run_reg[wi] == '1) ? run_reg[wi] : run_reg[wi] + 1'b1;
            end
            else
            begin
                st = tcs_pkg::ST_QUEUED;
            end
        end
        walk_done = !done_reg[wi] && (run_new >= burst_reg[wi]);
        ri_new    = (!rv_reg && st == tcs_pkg::ST_RUNNING) ? wi : ri_reg;
        rv_walk   = rv_new;
        if (walk_done && st == tcs_pkg::ST_RUNNING)
        begin
            rv_walk   = 1'b0;
            slice_new = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_phase_reg <= 1'b0;
        end
        else if (cmd.tick_start)
        begin
            walk_phase_reg <= 1'b1;
        end
        else if (cmd.finish)
        begin
            walk_phase_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
            begin
                run_reg[k]    <= '0;
                wait_reg[k]   <= '0;
                q_reg[k]      <= '0;
                res_st_reg[k] <= tcs_pkg::ST_NOT_ARRIVED;
            end
            ready_reg    <= '0;
            done_reg     <= '0;
            qlen_reg     <= '0;
            rv_reg       <= 1'b0;
            ri_reg       <= '0;
            slice_reg    <= '0;
            now_reg      <= '0;
            tick_now_reg <= '0;
            n_reg        <= '0;
            walk_reg     <= '0;
            fin_reg      <= 1'b0;
            si_reg       <= '0;
            sj_reg       <= '0;
            sin_reg      <= 1'b0;
            skey_reg     <= '0;
            kratio_reg   <= '0;
            dkey_reg     <= 1'b0;
            dq_reg       <= '0;
            drem_reg     <= '0;
            ddiv_reg     <= '0;
            dcnt_reg     <= '0;
            dbusy_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.tick_start)
            begin
                n_reg        <= n_eff;
                tick_now_reg <= now_reg;
                walk_reg     <= '0;
            end
            if (cmd.sort_init)
            begin
                si_reg  <= (IW+1)'(1);
                sin_reg <= 1'b0;
            end
            if (cmd.div_start)
            begin
                dkey_reg  <= !sin_reg;
                dq_reg    <= num;
                drem_reg  <= '0;
                ddiv_reg  <= den;
                dcnt_reg  <= 5'(DW);
                dbusy_reg <= 1'b1;
                if (!sin_reg)
                begin
                    skey_reg <= q_reg[si_reg[IW-1:0]];
                    sj_reg   <= si_reg;
                end
            end
            if (dbusy_reg)
            begin
                if (!trial[DW])
                begin
                    drem_reg <= trial[DW-1:0];
                    dq_reg   <= {dq_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= {drem_reg[DW-2:0], dq_reg[DW-1]};
                    dq_reg   <= {dq_reg[DW-2:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg - 1'b1;
                if (dcnt_reg == 5'd1)
                begin
                    dbusy_reg <= 1'b0;
                end
            end
            if (cmd.sort_step)
            begin
                if (dkey_reg)
                begin
                    kratio_reg <= rnow;
                    sin_reg    <= (sj_reg != '0);
                    if (sj_reg == '0)
                    begin
                        si_reg <= si_reg + 1'b1;
                    end
                end
                else if (rnow < kratio_reg)
                begin
                    q_reg[sj_reg[IW-1:0]] <= q_reg[sj_reg[IW-1:0] - 1'b1];
                    sj_reg <= sj_reg - 1'b1;
                    if (sj_reg == (IW+1)'(1))
                    begin
                        q_reg[0] <= skey_reg;
                        sin_reg  <= 1'b0;
                        si_reg   <= si_reg + 1'b1;
                    end
                end
                else
                begin
                    q_reg[sj_reg[IW-1:0]] <= skey_reg;
                    sin_reg <= 1'b0;
                    si_reg  <= si_reg + 1'b1;
                end
            end
            if (cmd.take_step)
            begin
                for (int k = 0; k < N - 1; k++)
                begin
                    q_reg[k] <= q_reg[k+1];
                end
                qlen_reg <= qlen_reg - 1'b1;
                if (head_ok)
                begin
                    rv_reg <= 1'b1;
                    ri_reg <= q_reg[0];
                end
            end
            if (cmd.preempt)
            begin
                if (qlen_reg < (IW+1)'(N))
                begin
                    q_reg[qlen_reg[IW-1:0]] <= ri_reg;
                    qlen_reg <= qlen_reg + 1'b1;
                end
                rv_reg    <= 1'b0;
                slice_reg <= '0;
            end
            if (cmd.walk_step && !cmd.finish)
            begin
                walk_reg <= stat.walk_last ? '0 : walk_reg + 1'b1;
            end
            if (cmd.walk_step && walk_phase_reg)
            begin
                res_st_reg[wi] <= st;
                run_reg[wi]    <= run_new;
                if (st == tcs_pkg::ST_WAITING || st == tcs_pkg::ST_QUEUED)
                begin
                    wait_reg[wi] <= (wait_reg[wi] == '1) ? wait_reg[wi] : wait_reg[wi] + 1'b1;
                end
                if (st == tcs_pkg::ST_QUEUED || (st == tcs_pkg::ST_RUNNING && !rv_reg))
                begin
                    ready_reg[wi] <= 1'b1;
                end
                if (st == tcs_pkg::ST_QUEUED && qlen_reg < (IW+1)'(N))
                begin
                    q_reg[qlen_reg[IW-1:0]] <= wi;
                    qlen_reg <= qlen_reg + 1'b1;
                end
                if (walk_done)
                begin
                    done_reg[wi] <= 1'b1;
                end
                rv_reg    <= rv_walk;
                ri_reg    <= ri_new;
                slice_reg <= slice_new;
            end
            if (cmd.finish)
            begin
                now_reg <= (now_reg == '1) ? now_reg : now_reg + 1'b1;
                fin_reg <= all_done_calc();
            end
        end
    end

endmodule

@@ hdl/tick_cpu_scheduler_fcfs_rr_hrrn.sv @@
// Tick-driven process scheduler with FCFS, round robin and HRRN dispatch.
// A load beat writes the process tables. After a tick beat the input is stalled through dispatch
// and walk (queue pops, a round robin preemption with a further pop, the walk of n entries),
// then n result beats follow, one per cycle while the output is not stalled.
// HRRN mode adds an insertion sort of the queue, with one ratio division per comparison (17-step divider).
// Reset clears counters, flags, queue and presets the registers; the tables hold no value until loaded.
module tick_cpu_scheduler_fcfs_rr_hrrn
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  tcs_pkg::in_item_t     in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output tcs_pkg::out_item_t    out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [1:0]     mode_reg;
    logic [7:0]     quantum_reg;
    logic [4:0]     count_reg;
    tcs_pkg::cmd_t  cmd;
    tcs_pkg::stat_t stat;
    logic           wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= tcs_pkg::MODE_FCFS;
            quantum_reg <= 8'd5;
            count_reg   <= 5'd16;
        end
        else if (wr)
        begin
            unique case (paddr[3:2])
                tcs_pkg::REG_MODE:    mode_reg    <= pwdata[1:0];
                tcs_pkg::REG_QUANTUM: quantum_reg <= pwdata[7:0];
                tcs_pkg::REG_COUNT:   count_reg   <= pwdata[4:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            tcs_pkg::REG_MODE:    prdata = {30'd0, mode_reg};
            tcs_pkg::REG_QUANTUM: prdata = {24'd0, quantum_reg};
            tcs_pkg::REG_COUNT:   prdata = {27'd0, count_reg};
            default:              prdata = '0;
        endcase
    end

    tcs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_op     (in_data.opcode),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .mode      (mode_reg),
        .stat      (stat),
        .cmd       (cmd)
    );

    tcs_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_item    (in_data),
        .mode       (mode_reg),
        .quantum    (quantum_reg),
        .proc_count (count_reg),
        .cmd        (cmd),
        .stat       (stat),
        .out_item   (out_data)
    );

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && !in_stall))
        else $error("input taken while results pending");

    a_last_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_data.last_of_tick) |=> !out_valid)
        else $error("result beat after last of tick");

    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.opcode == tcs_pkg::OP_LOAD) |=> !out_valid)
        else $error("load produced a result");

endmodule
